// ----- design/toac_pkg.sv -----
`default_nettype none

package toac_pkg;

  // input kinds
  localparam logic KIND_DIFF = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_DIFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_LOWER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_UPPER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FRESH   = 2'd3;
  localparam int unsigned CFG_DATA_W = 8;

  // register reset values
  localparam logic signed [7:0] TARGET_DIFF_RST = 8'sd2;
  localparam logic signed [7:0] BOUND_LOWER_RST = 8'sd1;
  localparam logic signed [7:0] BOUND_UPPER_RST = 8'sd3;
  localparam logic [5:0]        MIN_FRESH_RST   = 6'd3;

  // a diff is kept only strictly inside these limits
  localparam logic signed [15:0] DIFF_EXCL_MIN = -16'sd128;
  localparam logic signed [15:0] DIFF_EXCL_MAX = 16'sd127;

  // saturation limits of the adjustment
  localparam logic signed [8:0] ADJ_MAX = 9'sd127;
  localparam logic signed [8:0] ADJ_MIN = -9'sd128;

  typedef struct packed {
    logic update;
    logic sweep_start;
    logic div_start;
    logic result_load;
  } toac_cmd_t;

  typedef struct packed {
    logic sweep_busy;
    logic div_busy;
  } toac_status_t;

endpackage

`default_nettype wire

// ----- design/toac_if.sv -----
`default_nettype none

interface toac_req_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] diff_value;
  logic [7:0]         ack_iteration;

  modport source (output valid, output kind, output diff_value, output ack_iteration,
                  input ready);
  modport sink (input valid, input kind, input diff_value, input ack_iteration,
                output ready);
endinterface

interface toac_res_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] adjustment;
  logic [7:0]        iteration;
  logic              diff_rejected;
  logic              iteration_skipped;

  modport source (output valid, output adjustment, output iteration,
                  output diff_rejected, output iteration_skipped, input ready);
  modport sink (input valid, input adjustment, input iteration,
                input diff_rejected, input iteration_skipped, output ready);
endinterface

`default_nettype wire

// ----- design/toac_ctrl.sv -----
`default_nettype none

module toac_ctrl
  import toac_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         req_valid,
  output logic              req_ready,
  output logic              res_valid,
  input  wire logic         res_ready,
  input  wire toac_status_t status,
  output toac_cmd_t         cmd
);

  typedef enum logic [2:0] {
    IDLE,
    LOAD,
    SWEEP,
    DIVIDE,
    FINISH
  } state_t;

  state_t state;

  assign req_ready = (state == IDLE);

  always_comb begin
    cmd.update      = req_valid && req_ready;
    cmd.sweep_start = (state == LOAD);
    cmd.div_start   = (state == SWEEP) && !status.sweep_busy;
    cmd.result_load = (state == FINISH) && (!res_valid || res_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      res_valid <= 1'b0;
    end else begin
      if (cmd.result_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (req_valid) state <= LOAD;
        end
        LOAD: begin
          state <= SWEEP;
        end
        SWEEP: begin
          if (!status.sweep_busy) state <= DIVIDE;
        end
        DIVIDE: begin
          if (!status.div_busy) state <= FINISH;
        end
        FINISH: begin
          if (!res_valid || res_ready) state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/toac_dpath.sv -----
`default_nettype none

module toac_dpath
  import toac_pkg::*;
#(
  parameter int unsigned HISTORY_LEN = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  kind,
  input  wire logic signed [15:0]    diff_value,
  input  wire logic [7:0]            ack_iteration,
  input  wire toac_cmd_t             cmd,
  output toac_status_t               status,
  output logic signed [7:0]          adjustment,
  output logic [7:0]                 iteration,
  output logic                       diff_rejected,
  output logic                       iteration_skipped
);

  localparam int unsigned PTR_W = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
  localparam int unsigned CNT_W = $clog2(HISTORY_LEN + 1);
  localparam int unsigned SUM_W = 8 + CNT_W;
  localparam int unsigned DCW   = $clog2(SUM_W + 1);
  localparam int unsigned CMP_W = (CNT_W > 6) ? CNT_W : 6;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_LEN - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HISTORY_LEN);

  // configuration
  logic signed [7:0] target_diff;
  logic signed [7:0] bound_lower;
  logic signed [7:0] bound_upper;
  logic [5:0]        min_fresh;

  // history and its bookkeeping
  logic [7:0]             hist_mem [HISTORY_LEN];
  logic [HISTORY_LEN-1:0] hist_valid;
  logic [PTR_W-1:0]       newest_pos;
  logic [CNT_W-1:0]       fresh_count;
  logic [7:0]             last_iteration;
  logic                   rejected;
  logic                   skipped;

  // sweep
  logic                   issuing;
  logic [PTR_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       rd_cnt;
  logic [CNT_W-1:0]       n_reads;
  logic                   rd_pend;
  logic [CNT_W-1:0]       rd_age;
  logic [7:0]             rd_data;
  logic                   rd_hit;
  logic signed [7:0]      rd_val;
  logic [SUM_W-1:0]       sum;
  logic signed [7:0]      newest;
  logic signed [7:0]      prev;

  // divider
  logic                   div_busy;
  logic [DCW-1:0]         div_cnt;
  logic [SUM_W-1:0]       dvd;
  logic [SUM_W-1:0]       quo;
  logic [CNT_W-1:0]       rem;
  logic                   neg;
  logic [CNT_W:0]         trial;
  logic                   fits;

  // decision
  logic [PTR_W-1:0]       push_pos;
  logic                   diff_ok;
  logic [7:0]             expect_it;
  logic [7:0]             qmag;
  logic signed [7:0]      mean;
  logic signed [8:0]      delta;
  logic signed [7:0]      sat_delta;
  logic                   no_adjust;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_diff <= TARGET_DIFF_RST;
      bound_lower <= BOUND_LOWER_RST;
      bound_upper <= BOUND_UPPER_RST;
      min_fresh   <= MIN_FRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_DIFF: target_diff <= cfg_data[7:0];
        REG_BOUND_LOWER: bound_lower <= cfg_data[7:0];
        REG_BOUND_UPPER: bound_upper <= cfg_data[7:0];
        REG_MIN_FRESH:   min_fresh   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign push_pos  = (newest_pos == PTR_LAST) ? '0 : newest_pos + PTR_W'(1);
  assign diff_ok   = (diff_value > DIFF_EXCL_MIN) && (diff_value < DIFF_EXCL_MAX);
  assign expect_it = last_iteration + 8'd1;

  always_ff @(posedge clk) begin
    if (cmd.update && (kind == KIND_DIFF) && diff_ok) begin
      hist_mem[push_pos] <= diff_value[7:0];
    end
    if (issuing) begin
      rd_data <= hist_mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid     <= '0;
      newest_pos     <= '0;
      fresh_count    <= '0;
      last_iteration <= '0;
    end else if (cmd.update) begin
      if (kind == KIND_DIFF) begin
        if (diff_ok) begin
          newest_pos           <= push_pos;
          hist_valid[push_pos] <= 1'b1;
        end
        if (fresh_count != CNT_FULL) fresh_count <= fresh_count + CNT_W'(1);
      end else if (ack_iteration == expect_it) begin
        last_iteration <= expect_it;
        fresh_count    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      rejected <= (kind == KIND_DIFF) && !diff_ok;
      skipped  <= (kind == KIND_ACK) && (ack_iteration > expect_it);
    end
  end

  // entry one back is always needed for the lag spike test
  assign n_reads = (fresh_count < CNT_W'(2)) ? CNT_W'(2) : fresh_count;
  assign rd_val  = rd_hit ? rd_data : TARGET_DIFF_RST;

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      if (cmd.sweep_start) begin
        issuing <= 1'b1;
      end else if (issuing && (rd_cnt == n_reads - CNT_W'(1))) begin
        issuing <= 1'b0;
      end
      rd_pend <= issuing;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_start) begin
      rd_ptr <= newest_pos;
      rd_cnt <= '0;
      sum    <= '0;
    end else begin
      if (issuing) begin
        rd_ptr <= (rd_ptr == '0) ? PTR_LAST : rd_ptr - PTR_W'(1);
        rd_cnt <= rd_cnt + CNT_W'(1);
        rd_age <= rd_cnt;
        rd_hit <= hist_valid[rd_ptr];
      end
      if (rd_pend) begin
        if (rd_age == CNT_W'(0)) newest <= rd_val;
        if (rd_age == CNT_W'(1)) prev <= rd_val;
        if (rd_age < fresh_count) sum <= sum + {{(SUM_W-8){rd_val[7]}}, rd_val};
      end
    end
  end

  assign status.sweep_busy = issuing || rd_pend;
  assign status.div_busy   = div_busy;

  // restoring divide of the sum magnitude by the fresh count, one bit a cycle
  assign trial = {rem, dvd[SUM_W-1]};
  assign fits  = (trial >= {1'b0, fresh_count});

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
    end else if (div_busy && (div_cnt == DCW'(1))) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg     <= sum[SUM_W-1];
      dvd     <= sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
      quo     <= '0;
      rem     <= '0;
      div_cnt <= DCW'(SUM_W);
    end else if (div_busy) begin
      rem     <= fits ? CNT_W'(trial - {1'b0, fresh_count}) : trial[CNT_W-1:0];
      quo     <= {quo[SUM_W-2:0], fits};
      dvd     <= {dvd[SUM_W-2:0], 1'b0};
      div_cnt <= div_cnt - DCW'(1);
    end
  end

  // mean stays within the entry range, so the low byte carries it
  assign qmag = quo[7:0];
  always_comb begin
    if (fresh_count == '0) begin
      mean = '0;
    end else if (neg) begin
      mean = ~qmag + 8'd1;
    end else begin
      mean = qmag;
    end
  end

  assign delta = {target_diff[7], target_diff} - {mean[7], mean};

  always_comb begin
    priority if (delta > ADJ_MAX) begin
      sat_delta = ADJ_MAX[7:0];
    end else if (delta < ADJ_MIN) begin
      sat_delta = ADJ_MIN[7:0];
    end else begin
      sat_delta = delta[7:0];
    end
  end

  assign no_adjust = (CMP_W'(fresh_count) < CMP_W'(min_fresh))
                  || ((newest >= bound_lower) && (newest <= bound_upper))
                  || ((mean >= bound_lower) && (mean <= bound_upper))
                  || ((newest < target_diff) && (newest > prev));

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      adjustment        <= no_adjust ? 8'sd0 : sat_delta;
      iteration         <= last_iteration;
      diff_rejected     <= rejected;
      iteration_skipped <= skipped;
    end
  end

endmodule

`default_nettype wire

// ----- design/tick_offset_adjust_controller_top.sv -----
// one request at a time: after accept the controller steps through LOAD, SWEEP, DIVIDE and FINISH,
// loads the result in FINISH and returns to IDLE, where the next request is accepted
// the history sweep reads one entry a cycle and the mean divider resolves one bit a cycle
// a finished result sits in the output register, so the next request is taken meanwhile
// synchronous active-high reset: history reads back as the target reset value, counters,
// iteration and pointers clear, registers return to their reset values at once
`default_nettype none

module tick_offset_adjust_controller_top
  import toac_pkg::*;
#(
  parameter int unsigned HISTORY_LEN = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  toac_req_if.sink                   req,
  toac_res_if.source                 res
);

  toac_cmd_t    cmd;
  toac_status_t status;
  logic         req_ready;
  logic         res_valid;

  toac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res.ready),
    .status    (status),
    .cmd       (cmd)
  );

  toac_dpath #(
    .HISTORY_LEN (HISTORY_LEN)
  ) u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .kind              (req.kind),
    .diff_value        (req.diff_value),
    .ack_iteration     (req.ack_iteration),
    .cmd               (cmd),
    .status            (status),
    .adjustment        (res.adjustment),
    .iteration         (res.iteration),
    .diff_rejected     (res.diff_rejected),
    .iteration_skipped (res.iteration_skipped)
  );

  assign req.ready = req_ready;
  assign res.valid = res_valid;

endmodule

`default_nettype wire

// ----- design/toac_checker.sv -----
`default_nettype none

module toac_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic [7:0] adjustment,
  input wire logic [7:0] iteration,
  input wire logic       diff_rejected,
  input wire logic       iteration_skipped
);

  // a stalled result keeps its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(adjustment) && $stable(iteration)
      && $stable(diff_rejected) && $stable(iteration_skipped))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // one request in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // a request is either a diff or an acknowledge, never flagged both ways
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(diff_rejected && iteration_skipped))
    else $error("both flags set");

endmodule

bind tick_offset_adjust_controller_top toac_checker u_toac_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .res_valid         (res.valid),
  .res_ready         (res.ready),
  .adjustment        (res.adjustment),
  .iteration         (res.iteration),
  .diff_rejected     (res.diff_rejected),
  .iteration_skipped (res.iteration_skipped)
);

`default_nettype wire
